// ===== sv/stx_etx_escape_deframer_defines.svh =====
// assertion macros for the stx/etx escape deframer checker
// no dependencies; expects clock and reset in the scope of use
`ifndef STX_ETX_ESCAPE_DEFRAMER_DEFINES_SVH
`define STX_ETX_ESCAPE_DEFRAMER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define SED_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define SED_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/sed_pkg.sv =====
// shared types and constants for the stx/etx escape deframer
// no dependencies
package sed_pkg;

   localparam logic [7:0] SYM_STX       = 8'h02;
   localparam logic [7:0] SYM_ETX       = 8'h03;
   localparam logic [7:0] SYM_ESC       = 8'h1B;
   localparam logic [7:0] CODE_STX      = 8'hE7;
   localparam logic [7:0] CODE_ETX      = 8'hE8;
   localparam logic [7:0] CODE_ESC      = 8'h00;
   localparam logic [7:0] CHECK_MASK    = 8'h7F;
   localparam logic [7:0] MAX_LEN_RESET = 8'd44;
   localparam logic [7:0] MIN_ENOUGH    = 8'd3;

   typedef enum logic [1:0] {
      KIND_ID      = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_END     = 2'd2
   } sed_kind_type;

   typedef enum logic [2:0] {
      ERR_NONE       = 3'd0,
      ERR_BAD_ESCAPE = 3'd1,
      ERR_TOO_LONG   = 3'd2,
      ERR_RESTARTED  = 3'd3,
      ERR_TOO_SHORT  = 3'd4
   } sed_error_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] in_byte;
   } sed_stage_type;

   typedef struct packed {
      logic          valid;
      logic [7:0]    out_byte;
      sed_kind_type  out_kind;
      logic          checksum_ok;
      sed_error_type error_code;
   } sed_result_type;

endpackage

// ===== sv/sed_if.sv =====
// handshake channels for line bytes in and decoded items out
// depends on sed_pkg
interface sed_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

interface sed_rsp_if;
   import sed_pkg::*;
   logic          valid;
   logic          ready;
   logic [7:0]    out_byte;
   sed_kind_type  out_kind;
   logic          checksum_ok;
   sed_error_type error_code;

   modport source (output valid, output out_byte, output out_kind, output checksum_ok,
                   output error_code, input ready);
   modport sink (input valid, input out_byte, input out_kind, input checksum_ok,
                 input error_code, output ready);
endinterface

// ===== sv/sed_input_stage.sv =====
// input register for raw line bytes
// depends on sed_pkg
module sed_input_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic [7:0]         req_in_byte,
   output logic               req_ready,
   input  logic               out_free,
   output sed_pkg::sed_stage_type stage
);
   import sed_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic       accept;
   logic       step;

   assign step      = valid_ff && out_free;
   assign req_ready = !valid_ff || out_free;
   assign accept    = req_valid && req_ready;
   assign valid_in  = accept ? 1'b1 : (step ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff <= req_in_byte;
      end
   end

   assign stage.valid   = valid_ff;
   assign stage.in_byte = byte_ff;
endmodule

// ===== sv/sed_decoder.sv =====
// frame state, escape removal, hold-back and checksum
// one byte per cycle unless stalled; depends on sed_pkg
module sed_decoder (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [7:0]             csr_wdata,
   input  sed_pkg::sed_stage_type stage,
   input  logic                   out_free,
   output sed_pkg::sed_result_type result
);
   import sed_pkg::*;

   logic       step;
   logic [7:0] max_len_ff;
   logic       in_frame_ff, in_frame_in;
   logic       after_escape_ff, after_escape_in;
   logic [7:0] held_byte_ff, held_byte_in;
   logic       held_valid_ff, held_valid_in;
   logic       id_sent_ff, id_sent_in;
   logic [7:0] running_xor_ff, running_xor_in;
   logic [7:0] decoded_count_ff, decoded_count_in;
   logic       bad_escape_ff, bad_escape_in;
   logic       dec_valid;
   logic [7:0] dec_byte;
   logic       enough;
   logic [7:0] b;

   assign step = stage.valid && out_free;
   assign b    = stage.in_byte;

   always_comb begin
      in_frame_in        = in_frame_ff;
      after_escape_in    = after_escape_ff;
      held_byte_in       = held_byte_ff;
      held_valid_in      = held_valid_ff;
      id_sent_in         = id_sent_ff;
      running_xor_in     = running_xor_ff;
      decoded_count_in   = decoded_count_ff;
      bad_escape_in      = bad_escape_ff;
      result.valid       = 1'b0;
      result.out_byte    = 8'd0;
      result.out_kind    = KIND_END;
      result.checksum_ok = 1'b0;
      result.error_code  = ERR_NONE;
      dec_valid          = 1'b0;
      dec_byte           = b;
      enough             = decoded_count_ff >= MIN_ENOUGH;

      if (b == SYM_STX) begin
         if (in_frame_ff) begin
            result.valid      = 1'b1;
            result.error_code = ERR_RESTARTED;
         end
         in_frame_in      = 1'b1;
         after_escape_in  = 1'b0;
         held_byte_in     = 8'd0;
         held_valid_in    = 1'b0;
         id_sent_in       = 1'b0;
         running_xor_in   = 8'd0;
         decoded_count_in = 8'd1;
         bad_escape_in    = 1'b0;
      end else if (in_frame_ff) begin
         if (b == SYM_ETX) begin
            result.valid       = 1'b1;
            result.checksum_ok = enough && held_valid_ff &&
                                 (held_byte_ff == (running_xor_ff & CHECK_MASK));
            if (bad_escape_ff || after_escape_ff) begin
               result.error_code = ERR_BAD_ESCAPE;
            end else if (!enough) begin
               result.error_code = ERR_TOO_SHORT;
            end
            in_frame_in      = 1'b0;
            after_escape_in  = 1'b0;
            held_byte_in     = 8'd0;
            held_valid_in    = 1'b0;
            id_sent_in       = 1'b0;
            running_xor_in   = 8'd0;
            decoded_count_in = 8'd0;
            bad_escape_in    = 1'b0;
         end else begin
            if (after_escape_ff) begin
               after_escape_in = 1'b0;
               case (b)
                  CODE_STX: begin
                     dec_valid = 1'b1;
                     dec_byte  = SYM_STX;
                  end
                  CODE_ETX: begin
                     dec_valid = 1'b1;
                     dec_byte  = SYM_ETX;
                  end
                  CODE_ESC: begin
                     dec_valid = 1'b1;
                     dec_byte  = SYM_ESC;
                  end
                  default: begin
                     bad_escape_in = 1'b1;
                  end
               endcase
            end else if (b == SYM_ESC) begin
               after_escape_in = 1'b1;
            end else begin
               dec_valid = 1'b1;
            end

            if (dec_valid) begin
               if (({1'b0, decoded_count_ff} + 9'd1) >= {1'b0, max_len_ff}) begin
                  result.valid      = 1'b1;
                  result.error_code = ERR_TOO_LONG;
                  in_frame_in       = 1'b0;
                  after_escape_in   = 1'b0;
                  held_byte_in      = 8'd0;
                  held_valid_in     = 1'b0;
                  id_sent_in        = 1'b0;
                  running_xor_in    = 8'd0;
                  decoded_count_in  = 8'd0;
                  bad_escape_in     = 1'b0;
               end else begin
                  decoded_count_in = decoded_count_ff + 8'd1;
                  if (held_valid_ff) begin
                     result.valid    = 1'b1;
                     result.out_byte = held_byte_ff;
                     result.out_kind = id_sent_ff ? KIND_PAYLOAD : KIND_ID;
                     id_sent_in      = 1'b1;
                     running_xor_in  = running_xor_ff ^ held_byte_ff;
                  end
                  held_byte_in  = dec_byte;
                  held_valid_in = 1'b1;
               end
            end
         end
      end
      if (!step) begin
         result.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
      end else if (csr_we) begin
         max_len_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff      <= 1'b0;
         after_escape_ff  <= 1'b0;
         held_byte_ff     <= 8'd0;
         held_valid_ff    <= 1'b0;
         id_sent_ff       <= 1'b0;
         running_xor_ff   <= 8'd0;
         decoded_count_ff <= 8'd0;
         bad_escape_ff    <= 1'b0;
      end else if (step) begin
         in_frame_ff      <= in_frame_in;
         after_escape_ff  <= after_escape_in;
         held_byte_ff     <= held_byte_in;
         held_valid_ff    <= held_valid_in;
         id_sent_ff       <= id_sent_in;
         running_xor_ff   <= running_xor_in;
         decoded_count_ff <= decoded_count_in;
         bad_escape_ff    <= bad_escape_in;
      end
   end
endmodule

// ===== sv/sed_output_stage.sv =====
// result register toward the response channel
// depends on sed_pkg
module sed_output_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  sed_pkg::sed_result_type result,
   output logic                    out_free,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic [7:0]              rsp_out_byte,
   output sed_pkg::sed_kind_type   rsp_out_kind,
   output logic                    rsp_checksum_ok,
   output sed_pkg::sed_error_type  rsp_error_code
);
   import sed_pkg::*;

   logic           valid_ff;
   logic           valid_in;
   sed_result_type data_ff;

   assign out_free = !valid_ff || rsp_ready;
   assign valid_in = result.valid ? 1'b1 : (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         data_ff <= result;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = data_ff.out_byte;
   assign rsp_out_kind    = data_ff.out_kind;
   assign rsp_checksum_ok = data_ff.checksum_ok;
   assign rsp_error_code  = data_ff.error_code;
endmodule

// ===== sv/stx_etx_escape_deframer.sv =====
// Deframer for STX/ETX byte-stuffed serial frames: takes one raw line byte per item on req_ch
// and returns frame ID, payload and frame-end status items on rsp_ch, one byte per clock
// sustained while rsp_ch is ready. Each byte passes an input register, combinational decode
// logic and a result register; the input register can take the next byte while a result
// still waits in the response register. csr_we/csr_wdata set the largest frame length
// (reset 44); users write them only while the block is idle; the block does not enforce it.
module stx_etx_escape_deframer (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata,
   sed_req_if.sink    req_ch,
   sed_rsp_if.source  rsp_ch
);
   import sed_pkg::*;

   sed_stage_type  stage;
   sed_result_type result;
   logic           out_free;

   sed_input_stage u_input (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_in_byte (req_ch.in_byte),
      .req_ready   (req_ch.ready),
      .out_free    (out_free),
      .stage       (stage)
   );

   sed_decoder u_decoder (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .stage     (stage),
      .out_free  (out_free),
      .result    (result)
   );

   sed_output_stage u_output (
      .clock           (clock),
      .reset           (reset),
      .result          (result),
      .out_free        (out_free),
      .rsp_ready       (rsp_ch.ready),
      .rsp_valid       (rsp_ch.valid),
      .rsp_out_byte    (rsp_ch.out_byte),
      .rsp_out_kind    (rsp_ch.out_kind),
      .rsp_checksum_ok (rsp_ch.checksum_ok),
      .rsp_error_code  (rsp_ch.error_code)
   );
endmodule

// ===== sv/sed_checker.sv =====
// port-level checks for the deframer, bound to the top level
// depends on sed_pkg and stx_etx_escape_deframer_defines.svh
`include "stx_etx_escape_deframer_defines.svh"

module sed_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [7:0]             rsp_out_byte,
   input sed_pkg::sed_kind_type  rsp_out_kind,
   input logic                   rsp_checksum_ok,
   input sed_pkg::sed_error_type rsp_error_code
);
   import sed_pkg::*;

   logic        rsp_stall;
   logic [13:0] rsp_payload;
   logic        byte_item;
   logic        end_item;
   logic        status_clear;
   logic        ok_end;
   logic        err_uncut;

   assign rsp_stall    = rsp_valid && !rsp_ready;
   assign rsp_payload  = {rsp_out_byte, rsp_out_kind, rsp_checksum_ok, rsp_error_code};
   assign byte_item    = rsp_valid && rsp_out_kind != KIND_END;
   assign end_item     = rsp_valid && rsp_out_kind == KIND_END;
   assign status_clear = !rsp_checksum_ok && rsp_error_code == ERR_NONE;
   assign ok_end       = end_item && rsp_checksum_ok;
   assign err_uncut    = rsp_error_code == ERR_NONE || rsp_error_code == ERR_BAD_ESCAPE;

   `SED_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_payload), "stalled item changed")
   `SED_ASSERT_SAME(a_byte_clean, byte_item, status_clear, "byte item carries status")
   `SED_ASSERT_SAME(a_end_zero, end_item, rsp_out_byte == 8'd0, "frame end item has nonzero byte")
   `SED_ASSERT_SAME(a_ok_err, ok_end, err_uncut, "checksum ok on a cut frame")
endmodule

bind stx_etx_escape_deframer sed_checker u_sed_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_out_byte    (rsp_ch.out_byte),
   .rsp_out_kind    (rsp_ch.out_kind),
   .rsp_checksum_ok (rsp_ch.checksum_ok),
   .rsp_error_code  (rsp_ch.error_code)
);

// ===== bench/tb.sv =====
// self-checking bench for stx_etx_escape_deframer: line bytes in, decoded items out
// depends on sed_pkg, sed_req_if, sed_rsp_if and the deframer rtl
// an in-bench deframer predicts every item; frames are mostly well formed, some broken
`timescale 1ns / 1ps

module tb;
   import sed_pkg::*;

   typedef struct packed {
      logic [7:0]    data;
      sed_kind_type  kind;
      logic          ok;
      sed_error_type err;
   } deframed_item_type;

   typedef enum {
      FLAW_NONE,
      FLAW_BAD_CHECK,
      FLAW_BAD_ESCAPE,
      FLAW_OPEN_ESCAPE,
      FLAW_RESTART,
      FLAW_ESC_RESTART
   } frame_flaw_type;

   logic       clock;
   logic       reset;
   logic       csr_we;
   logic [7:0] csr_wdata;

   sed_req_if req_ch ();
   sed_rsp_if rsp_ch ();

   stx_etx_escape_deframer DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   logic [7:0]        line_bytes_q[$];
   logic [7:0]        frame_body[$];
   deframed_item_type deframed_q[$];
   int                frame_items;
   int                fail_count = 0;
   int                sender_idle_pct;
   int                receiver_idle_pct;

   // predicted deframer state
   logic [7:0] max_len    = MAX_LEN_RESET;
   logic       in_frame   = 1'b0;
   logic       esc_pending = 1'b0;
   logic [7:0] held_byte  = '0;
   logic       held_valid = 1'b0;
   logic       id_sent    = 1'b0;
   logic [7:0] frame_xor  = '0;
   logic [7:0] frame_len  = '0;
   logic       bad_esc    = 1'b0;

   always #1 clock = ~clock;

   task automatic clear_frame_state();
      in_frame = 1'b0;
      esc_pending = 1'b0;
      held_byte = '0;
      held_valid = 1'b0;
      id_sent = 1'b0;
      frame_xor = '0;
      frame_len = '0;
      bad_esc = 1'b0;
   endtask

   task automatic push_deframed(input logic [7:0] b, input sed_kind_type k, input logic ok,
                                input sed_error_type e);
      deframed_item_type r;
      r.data = b;
      r.kind = k;
      r.ok = ok;
      r.err = e;
      deframed_q.push_back(r);
   endtask

   task automatic take_decoded(input logic [7:0] b);
      if ({1'b0, frame_len} + 9'd1 >= {1'b0, max_len}) begin
         push_deframed(8'h00, KIND_END, 1'b0, ERR_TOO_LONG);
         clear_frame_state();
      end else begin
         frame_len = frame_len + 8'd1;
         if (held_valid) begin
            push_deframed(held_byte, id_sent ? KIND_PAYLOAD : KIND_ID, 1'b0, ERR_NONE);
            id_sent = 1'b1;
            frame_xor = frame_xor ^ held_byte;
         end
         held_byte = b;
         held_valid = 1'b1;
      end
   endtask

   task automatic deframe_byte(input logic [7:0] b);
      logic          enough;
      logic          ok;
      sed_error_type e;
      if (b == SYM_STX) begin
         if (in_frame)
            push_deframed(8'h00, KIND_END, 1'b0, ERR_RESTARTED);
         clear_frame_state();
         in_frame = 1'b1;
         frame_len = 8'd1;
      end else if (in_frame) begin
         if (b == SYM_ETX) begin
            enough = (frame_len >= MIN_ENOUGH);
            ok = enough && held_valid && (held_byte == (frame_xor & CHECK_MASK));
            if (bad_esc || esc_pending)
               e = ERR_BAD_ESCAPE;
            else if (!enough)
               e = ERR_TOO_SHORT;
            else
               e = ERR_NONE;
            push_deframed(8'h00, KIND_END, ok, e);
            clear_frame_state();
         end else if (esc_pending) begin
            esc_pending = 1'b0;
            if (b == CODE_STX)
               take_decoded(SYM_STX);
            else if (b == CODE_ETX)
               take_decoded(SYM_ETX);
            else if (b == CODE_ESC)
               take_decoded(SYM_ESC);
            else
               bad_esc = 1'b1;
         end else if (b == SYM_ESC) begin
            esc_pending = 1'b1;
         end else begin
            take_decoded(b);
         end
      end
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.in_byte <= '0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            deframe_byte(req_ch.in_byte);
         if (!req_ch.valid || req_ch.ready) begin
            if (line_bytes_q.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               req_ch.valid <= 1'b1;
               req_ch.in_byte <= line_bytes_q.pop_front();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin : receiver
      deframed_item_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (deframed_q.size() == 0) begin
               $display("%0t: unexpected item byte %h kind %0d ok %b err %0d", $time,
                        rsp_ch.out_byte, rsp_ch.out_kind, rsp_ch.checksum_ok,
                        rsp_ch.error_code);
               fail_count++;
            end else begin
               want = deframed_q.pop_front();
               if (rsp_ch.out_byte !== want.data || rsp_ch.out_kind !== want.kind ||
                   rsp_ch.checksum_ok !== want.ok || rsp_ch.error_code !== want.err) begin
                  $display("%0t: expected %h/%0d/%b/%0d, got %h/%0d/%b/%0d",
                           $time, want.data, want.kind, want.ok, want.err, rsp_ch.out_byte,
                           rsp_ch.out_kind, rsp_ch.checksum_ok, rsp_ch.error_code);
                  fail_count++;
               end
            end
         end
         rsp_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
   end

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 15))
         0:       return SYM_STX;
         1:       return SYM_ETX;
         2:       return SYM_ESC;
         3:       return CODE_STX;
         4:       return CODE_ETX;
         5:       return 8'h00;
         6:       return 8'hFF;
         7:       return 8'h80;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic push_line(input logic [7:0] b);
      line_bytes_q.push_back(b);
      frame_items++;
   endtask

   task automatic emit_coded(input logic [7:0] b);
      if (b == SYM_STX) begin
         push_line(SYM_ESC);
         push_line(CODE_STX);
      end else if (b == SYM_ETX) begin
         push_line(SYM_ESC);
         push_line(CODE_ETX);
      end else if (b == SYM_ESC) begin
         push_line(SYM_ESC);
         push_line(CODE_ESC);
      end else begin
         push_line(b);
      end
   endtask

   task automatic send_frame(input logic with_check, input frame_flaw_type flaw);
      logic [7:0] sum;
      logic [7:0] odd;
      sum = '0;
      push_line(SYM_STX);
      foreach (frame_body[i]) begin
         emit_coded(frame_body[i]);
         sum = sum ^ frame_body[i];
      end
      if (flaw == FLAW_BAD_ESCAPE) begin
         odd = 8'($urandom_range(0, 255));
         if (odd == CODE_STX || odd == CODE_ETX || odd == CODE_ESC || odd == SYM_STX ||
             odd == SYM_ETX)
            odd = SYM_ESC;
         push_line(SYM_ESC);
         push_line(odd);
      end
      if (with_check) begin
         if (flaw == FLAW_BAD_CHECK)
            emit_coded((sum & CHECK_MASK) ^ (8'h01 << $urandom_range(0, 7)));
         else
            emit_coded(sum & CHECK_MASK);
      end
      case (flaw)
         FLAW_RESTART: begin
         end
         FLAW_ESC_RESTART: begin
            push_line(SYM_ESC);
         end
         FLAW_OPEN_ESCAPE: begin
            push_line(SYM_ESC);
            push_line(SYM_ETX);
         end
         default: begin
            push_line(SYM_ETX);
         end
      endcase
   endtask

   task automatic random_phase(input int target);
      int             n;
      int             r;
      frame_flaw_type flaw;
      logic [7:0]     b;
      frame_items = 0;
      while (frame_items < target) begin
         r = $urandom_range(0, 99);
         if (r < 6) begin
            // line noise, ignored outside a frame
            repeat ($urandom_range(1, 4)) begin
               b = 8'($urandom_range(0, 255));
               line_bytes_q.push_back(b == SYM_STX ? SYM_ETX : b);
            end
         end else begin
            r = $urandom_range(0, 99);
            if (r < 85)
               n = $urandom_range(0, 8);
            else if (r < 97)
               n = $urandom_range(9, 40);
            else
               n = int'(max_len) - 1 + $urandom_range(0, 2);
            r = $urandom_range(0, 99);
            if (r < 60)      flaw = FLAW_NONE;
            else if (r < 72) flaw = FLAW_BAD_CHECK;
            else if (r < 80) flaw = FLAW_BAD_ESCAPE;
            else if (r < 86) flaw = FLAW_OPEN_ESCAPE;
            else if (r < 94) flaw = FLAW_RESTART;
            else             flaw = FLAW_ESC_RESTART;
            frame_body.delete();
            repeat ((n < 2) ? n : n - 1)
               frame_body.push_back(pick_byte());
            send_frame(n >= 2, flaw);
         end
      end
      frame_body = '{8'h11, 8'h22};
      send_frame(1'b1, FLAW_NONE);
   endtask

   task automatic wait_idle();
      do
         @(negedge clock);
      while (line_bytes_q.size() != 0 || req_ch.valid || deframed_q.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_max_len(input logic [7:0] v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      max_len = v;
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.in_byte = '0;
      rsp_ch.ready = 1'b0;
      sender_idle_pct = 35;
      receiver_idle_pct = 57;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      line_bytes_q.push_back(SYM_ETX);
      line_bytes_q.push_back(8'hFF);
      frame_body = '{8'h00, 8'hFF, SYM_ESC, SYM_STX, SYM_ETX};
      send_frame(1'b1, FLAW_NONE);
      frame_body = '{8'h7F};
      send_frame(1'b1, FLAW_BAD_CHECK);
      frame_body.delete();
      send_frame(1'b0, FLAW_NONE);
      send_frame(1'b0, FLAW_ESC_RESTART);
      send_frame(1'b0, FLAW_BAD_ESCAPE);
      send_frame(1'b0, FLAW_OPEN_ESCAPE);
      wait_idle();

      for (int p = 1; p <= 5; p++) begin
         if (p == 2) begin
            sender_idle_pct = 57;
            receiver_idle_pct = 35;
         end else if (p == 4) begin
            sender_idle_pct = 0;
            receiver_idle_pct = 0;
         end
         case (p)
            1:       write_max_len(8'd4);
            2:       write_max_len(8'd255);
            3:       write_max_len(8'($urandom_range(5, 40)));
            4:       write_max_len(8'($urandom_range(41, 254)));
            default: write_max_len(MAX_LEN_RESET);
         endcase
         random_phase(85);
         wait_idle();
      end

      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #2000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
